>>> rtl/iprh_pkg.sv
// shared types and constants for the indexed priority ready heap
package iprh_pkg;

	localparam int THREADS = 64;
	localparam int TW = 6;
	localparam int PW = 8;
	localparam int SLOTS = 64;
	localparam int CW = 7;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_PRESENT = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS,
		S_RM0,
		S_RM1,
		S_RM2,
		S_UP0,
		S_UP1,
		S_UP2,
		S_DN0,
		S_DN1,
		S_DN2,
		S_DN3,
		S_DN4,
		S_SW0,
		S_SW1,
		S_FIN,
		S_DONE
	} state_t;

endpackage

>>> rtl/iprh_store.sv
// heap slot array and per-thread position and priority arrays
module iprh_store (
	input  logic                      clk,
	input  logic                      hs_we,
	input  logic [iprh_pkg::TW-1:0]   hs_wa,
	input  logic [iprh_pkg::TW-1:0]   hs_wd,
	input  logic [iprh_pkg::TW-1:0]   hs_ra,
	output logic [iprh_pkg::TW-1:0]   hs_rd,
	input  logic                      so_we,
	input  logic [iprh_pkg::TW-1:0]   so_wa,
	input  logic [iprh_pkg::TW-1:0]   so_wd,
	input  logic [iprh_pkg::TW-1:0]   so_ra,
	output logic [iprh_pkg::TW-1:0]   so_rd,
	input  logic                      pr_we,
	input  logic [iprh_pkg::TW-1:0]   pr_wa,
	input  logic [iprh_pkg::PW-1:0]   pr_wd,
	input  logic [iprh_pkg::TW-1:0]   pr_ra,
	output logic [iprh_pkg::PW-1:0]   pr_rd
);
	import iprh_pkg::*;

	logic [TW-1:0] hs_mem [SLOTS];
	logic [TW-1:0] so_mem [THREADS];
	logic [PW-1:0] pr_mem [THREADS];

	always_ff @(posedge clk) begin
		if (hs_we) hs_mem[hs_wa] <= hs_wd;
		hs_rd <= hs_mem[hs_ra];
	end

	always_ff @(posedge clk) begin
		if (so_we) so_mem[so_wa] <= so_wd;
		so_rd <= so_mem[so_ra];
	end

	always_ff @(posedge clk) begin
		if (pr_we) pr_mem[pr_wa] <= pr_wd;
		pr_rd <= pr_mem[pr_ra];
	end

endmodule

>>> rtl/indexed_priority_ready_heap_core.sv
// indexed priority ready heap top level: sequencer, compare unit and result port
// A request is taken when start is high and busy low; busy then stays high until the
// single result is shown for one cycle with done high, and drops in the cycle after.
// An ignored request goes straight to the result; an insert writes the new thread to the
// first free slot and moves it up level by level, and a remove puts the last thread into
// the freed slot and moves it up or down as needed. Each heap level costs a slot read,
// a priority read behind it, a compare on the one shared comparator and a swap written in
// the states S_SW0 and S_SW1, since every store has one registered read port and one
// write port. Results cannot be stalled. The contents of slots above the count and of
// entries of absent threads are never used, so the stores need no clearing.
module indexed_priority_ready_heap_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [iprh_pkg::TW-1:0]      thread_num,
	input  logic [iprh_pkg::PW-1:0]      thread_priority,
	output logic                         done,
	output logic [iprh_pkg::TW-1:0]      top_thread,
	output logic                         heap_empty,
	output logic [iprh_pkg::CW-1:0]      ready_count,
	output logic [1:0]                   status
);
	import iprh_pkg::*;

	state_t state_q, state_d;
	logic [THREADS-1:0] pres_q;
	logic [CW-1:0] count_q;
	logic [TW-1:0] thr_q, h_q, c_q, tm_q, tc_q, tr_q;
	logic [PW-1:0] pm_q, pl_q;
	logic [1:0] status_q;
	logic down_q;

	logic hs_we, so_we, pr_we;
	logic [TW-1:0] hs_wa, hs_wd, hs_ra, hs_rd, so_wa, so_wd, so_ra, so_rd, pr_wa, pr_ra;
	logic [PW-1:0] pr_rd;

	iprh_store u_store (
		.clk(clk),
		.hs_we(hs_we), .hs_wa(hs_wa), .hs_wd(hs_wd), .hs_ra(hs_ra), .hs_rd(hs_rd),
		.so_we(so_we), .so_wa(so_wa), .so_wd(so_wd), .so_ra(so_ra), .so_rd(so_rd),
		.pr_we(pr_we), .pr_wa(pr_wa), .pr_wd(pm_q), .pr_ra(pr_ra), .pr_rd(pr_rd)
	);

	logic [CW:0] l_w, r_w;
	logic [TW-1:0] parent_w;
	logic [CW-1:0] last_w;
	logic r_ok;
	logic [PW-1:0] cmp_a, cmp_b;
	logic cmp_lt, cmp_eq;
	logic go_right;

	assign busy = (state_q != S_IDLE);
	assign parent_w = (h_q - 1'b1) >> 1;
	assign l_w = {1'b0, h_q, 1'b1};
	assign r_w = l_w + 1'b1;
	assign last_w = count_q - 1'b1;
	assign r_ok = (r_w < {1'b0, count_q});

	// shared compare unit
	assign cmp_lt = (cmp_a < cmp_b);
	assign cmp_eq = (cmp_a == cmp_b);
	// ties between the children go right
	assign go_right = r_ok && (cmp_lt || cmp_eq);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) begin
				if (req_type == REQ_INSERT) begin
					if (pres_q[thread_num] || count_q >= CW'(SLOTS)) state_d = S_FIN;
					else state_d = S_INS;
				end else begin
					if (!pres_q[thread_num] || count_q == '0) state_d = S_FIN;
					else state_d = S_RM0;
				end
			end
			S_INS: state_d = S_UP0;
			S_RM0: state_d = S_RM1;
			S_RM1: state_d = S_RM2;
			S_RM2: begin
				if (cmp_lt) state_d = S_UP0;
				else if (!cmp_eq) state_d = S_DN0;
				else state_d = S_FIN;
			end
			S_UP0: state_d = (h_q == '0) ? S_FIN : S_UP1;
			S_UP1: state_d = S_UP2;
			S_UP2: state_d = cmp_lt ? S_SW0 : S_FIN;
			S_DN0: state_d = (l_w >= {1'b0, count_q}) ? S_FIN : S_DN1;
			S_DN1: state_d = S_DN2;
			S_DN2: state_d = S_DN3;
			S_DN3: state_d = S_DN4;
			S_DN4: state_d = (cmp_lt || cmp_eq) ? S_FIN : S_SW0;
			S_SW0: state_d = S_SW1;
			S_SW1: state_d = down_q ? S_DN0 : S_UP0;
			S_FIN: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port and comparator control
	always_comb begin
		hs_we = 1'b0; so_we = 1'b0; pr_we = 1'b0;
		hs_wa = h_q; hs_wd = tm_q; so_wa = tm_q; so_wd = h_q; pr_wa = thr_q;
		hs_ra = '0; so_ra = thr_q; pr_ra = thr_q;
		cmp_a = pm_q; cmp_b = pr_rd;
		case (state_q)
			S_INS: begin
				hs_we = 1'b1; hs_wa = count_q[TW-1:0]; hs_wd = thr_q;
				so_we = 1'b1; so_wa = thr_q; so_wd = count_q[TW-1:0];
				pr_we = 1'b1;
			end
			S_RM0: begin
				hs_ra = last_w[TW-1:0];
			end
			S_RM1: begin
				pr_ra = hs_rd;
			end
			S_RM2: begin
				// last thread takes the removed thread's slot
				hs_we = 1'b1; so_we = 1'b1;
				cmp_a = pr_rd; cmp_b = pl_q;
			end
			S_UP0: begin
				hs_ra = parent_w;
			end
			S_UP1: begin
				pr_ra = hs_rd;
			end
			S_DN0: begin
				hs_ra = l_w[TW-1:0];
			end
			S_DN1: begin
				hs_ra = r_ok ? r_w[TW-1:0] : l_w[TW-1:0];
				pr_ra = hs_rd;
			end
			S_DN2: begin
				pr_ra = hs_rd;
			end
			S_DN3: begin
				cmp_a = pr_rd; cmp_b = pl_q;
			end
			S_DN4: begin
				cmp_a = pm_q; cmp_b = pl_q;
			end
			S_SW0: begin
				hs_we = 1'b1; so_we = 1'b1;
				hs_wa = c_q; hs_wd = tm_q; so_wa = tm_q; so_wd = c_q;
			end
			S_SW1: begin
				hs_we = 1'b1; so_we = 1'b1;
				hs_wa = h_q; hs_wd = tc_q; so_wa = tc_q; so_wd = h_q;
			end
			S_FIN: begin
				hs_ra = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pres_q <= '0;
			count_q <= '0;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: if (start) begin
					if (req_type == REQ_INSERT) begin
						if (pres_q[thread_num]) status_q <= ST_PRESENT;
						else if (count_q >= CW'(SLOTS)) status_q <= ST_FULL;
						else status_q <= ST_OK;
					end else begin
						status_q <= (!pres_q[thread_num] || count_q == '0) ? ST_ABSENT : ST_OK;
					end
				end
				S_INS: begin
					pres_q[thr_q] <= 1'b1;
					count_q <= count_q + 1'b1;
				end
				S_RM1: begin
					pres_q[thr_q] <= 1'b0;
					count_q <= last_w;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				thr_q <= thread_num;
				pm_q <= thread_priority;
				tm_q <= thread_num;
			end
			S_INS: h_q <= count_q[TW-1:0];
			S_RM1: begin
				// so_rd is the removed thread's slot, hs_rd the last thread
				h_q <= (so_rd > last_w[TW-1:0]) ? last_w[TW-1:0] : so_rd;
				tm_q <= hs_rd;
				pl_q <= pr_rd;
			end
			S_RM2: pm_q <= pr_rd;
			S_UP0: c_q <= parent_w;
			S_UP1: tc_q <= hs_rd;
			S_UP2: down_q <= 1'b0;
			S_DN1: tc_q <= hs_rd;
			S_DN2: begin
				pl_q <= pr_rd;
				tr_q <= hs_rd;
			end
			S_DN3: begin
				c_q <= go_right ? r_w[TW-1:0] : l_w[TW-1:0];
				if (go_right) begin
					tc_q <= tr_q;
					pl_q <= pr_rd;
				end
			end
			S_DN4: down_q <= 1'b1;
			S_SW1: h_q <= c_q;
			default: ;
		endcase
	end

	assign done = (state_q == S_DONE);
	assign top_thread = (count_q != '0) ? hs_rd : '0;
	assign heap_empty = (count_q == '0);
	assign ready_count = count_q;
	assign status = status_q;

`ifndef SYNTH
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without request");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS)) else $error("count overflow");
	a_pres: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ($countones(pres_q) == int'(count_q))) else $error("count mismatch");
`endif

endmodule

>>> tb/tb_indexed_priority_ready_heap_core.sv
// testbench for the indexed priority ready heap core: scoreboard against a behavioral heap
module tb_indexed_priority_ready_heap_core;
	import iprh_pkg::*;

	typedef struct packed {
		logic          kind;
		logic [TW-1:0] thread;
		logic [PW-1:0] prio;
	} heap_req_t;

	typedef struct packed {
		logic [TW-1:0] top;
		logic          empty;
		logic [CW-1:0] cnt;
		logic [1:0]    st;
	} heap_rsp_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic          req_type;
	logic [TW-1:0] thread_num;
	logic [PW-1:0] thread_priority;
	logic          done;
	logic [TW-1:0] top_thread;
	logic          heap_empty;
	logic [CW-1:0] ready_count;
	logic [1:0]    status;

	indexed_priority_ready_heap_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .thread_num(thread_num), .thread_priority(thread_priority),
		.done(done), .top_thread(top_thread), .heap_empty(heap_empty),
		.ready_count(ready_count), .status(status)
	);

	// behavioral heap state
	int unsigned slot_thread [SLOTS];
	int unsigned thread_slot [THREADS];
	int unsigned thread_prio [THREADS];
	bit          in_heap [THREADS];
	int unsigned heap_cnt = 0;

	heap_req_t pending_reqs [$];
	heap_rsp_t expected_rsps [$];
	int        send_idle_pct;
	bit        hold_send;
	bit        stim_done;
	int        errors = 0;
	int        cycle_cnt = 0;

	function automatic int unsigned prio_of_slot(int unsigned s);
		return thread_prio[slot_thread[s]];
	endfunction

	function automatic void swap_heap(int unsigned a, int unsigned b);
		int unsigned ta;
		int unsigned tb;
		ta = slot_thread[a];
		tb = slot_thread[b];
		slot_thread[a] = tb;
		slot_thread[b] = ta;
		thread_slot[ta] = b;
		thread_slot[tb] = a;
	endfunction

	function automatic void bubble_up(int unsigned h);
		int unsigned p;
		int unsigned par;
		p = prio_of_slot(h);
		while (h > 0) begin
			par = (h - 1) / 2;
			if (p >= prio_of_slot(par))
				break;
			swap_heap(h, par);
			h = par;
		end
	endfunction

	function automatic void bubble_down(int unsigned h);
		int unsigned p;
		int unsigned l;
		int unsigned c;
		p = prio_of_slot(h);
		forever begin
			l = 2 * h + 1;
			if (l >= heap_cnt)
				break;
			// ties pick the right child
			if (l + 1 >= heap_cnt)
				c = l;
			else
				c = (prio_of_slot(l) < prio_of_slot(l + 1)) ? l : l + 1;
			if (p <= prio_of_slot(c))
				break;
			swap_heap(h, c);
			h = c;
		end
	endfunction

	function automatic heap_rsp_t apply_request(heap_req_t r);
		heap_rsp_t o;
		int unsigned h1;
		int unsigned h2;
		int unsigned p1;
		int unsigned p2;
		o.st = ST_OK;
		if (r.kind == REQ_INSERT) begin
			if (in_heap[r.thread])
				o.st = ST_PRESENT;
			else if (heap_cnt >= SLOTS)
				o.st = ST_FULL;
			else begin
				thread_prio[r.thread] = r.prio;
				slot_thread[heap_cnt] = r.thread;
				thread_slot[r.thread] = heap_cnt;
				in_heap[r.thread] = 1;
				heap_cnt++;
				bubble_up(heap_cnt - 1);
			end
		end else begin
			if (!in_heap[r.thread] || heap_cnt == 0)
				o.st = ST_ABSENT;
			else begin
				h1 = thread_slot[r.thread];
				h2 = heap_cnt - 1;
				if (h1 > h2)
					h1 = h2;
				swap_heap(h1, h2);
				p1 = prio_of_slot(h1);
				p2 = prio_of_slot(h2);
				heap_cnt = h2;
				in_heap[r.thread] = 0;
				if (p1 < p2)
					bubble_up(h1);
				else if (p1 > p2)
					bubble_down(h1);
			end
		end
		o.top = (heap_cnt > 0) ? slot_thread[0][TW-1:0] : '0;
		o.empty = (heap_cnt == 0);
		o.cnt = heap_cnt[CW-1:0];
		return o;
	endfunction

	function automatic void queue_req(logic k, int unsigned t, int unsigned p);
		heap_req_t r;
		r.kind = k;
		r.thread = t[TW-1:0];
		r.prio = p[PW-1:0];
		pending_reqs.push_back(r);
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			req_type <= 0;
			thread_num <= '0;
			thread_priority <= '0;
		end else if (start && busy) begin
			// beat not yet taken
		end else if (pending_reqs.size() > 0 && !hold_send &&
				$urandom_range(99) >= send_idle_pct) begin
			heap_req_t r;
			r = pending_reqs.pop_front();
			expected_rsps.push_back(apply_request(r));
			start <= 1;
			req_type <= r.kind;
			thread_num <= r.thread;
			thread_priority <= r.prio;
		end else begin
			start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			heap_rsp_t e;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (top_thread !== e.top) begin
					$error("top_thread exp %0d got %0d", e.top, top_thread);
					errors++;
				end
				if (heap_empty !== e.empty) begin
					$error("heap_empty exp %0d got %0d", e.empty, heap_empty);
					errors++;
				end
				if (ready_count !== e.cnt) begin
					$error("ready_count exp %0d got %0d", e.cnt, ready_count);
					errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 200000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned t;
		int unsigned k;
		hold_send = 0;
		send_idle_pct = 28;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: empty remove, priority extremes, ties, duplicate, fill
		queue_req(REQ_REMOVE, 0, 0);
		queue_req(REQ_INSERT, 63, 255);
		queue_req(REQ_INSERT, 0, 0);
		queue_req(REQ_INSERT, 5, 0);
		queue_req(REQ_INSERT, 7, 128);
		queue_req(REQ_INSERT, 9, 128);
		queue_req(REQ_INSERT, 0, 3);
		queue_req(REQ_REMOVE, 0, 170);
		queue_req(REQ_REMOVE, 0, 85);
		queue_req(REQ_REMOVE, 9, 0);
		queue_req(REQ_REMOVE, 7, 0);
		queue_req(REQ_REMOVE, 63, 0);
		queue_req(REQ_REMOVE, 5, 0);
		for (int i = 0; i < 65; i++)
			queue_req(REQ_INSERT, i % 64, $urandom_range(255));
		for (int i = 0; i < 10; i++)
			queue_req(REQ_REMOVE, $urandom_range(63), 0);
		wait_drained();

		// all results are back; pause sending before the random phase
		hold_send = 1;
		repeat (30) @(posedge clk);
		hold_send = 0;

		// random: mostly valid inserts/removes, some duplicates/absent
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 51 : 0;
			for (int i = 0; i < 160; i++) begin
				k = $urandom_range(99);
				t = $urandom_range(63);
				if (k < 55)
					queue_req(REQ_INSERT, t, (k < 10) ? $urandom_range(3) :
						$urandom_range(255));
				else
					queue_req(REQ_REMOVE, t, $urandom_range(255));
			end
			wait_drained();
		end
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
